### rtl/core/mbpoll_pkg.sv
// Package for the Modbus RTU input register poller.
// Holds the item and status codes, register indexes and the CRC-16 byte update.
// Used by modbus_rtu_input_register_poller_top, poll_checker and tb; depends on nothing else.
package mbpoll_pkg;

  localparam int MAX_REGS  = 32;
  localparam int REG_IDX_W = $clog2(MAX_REGS);
  localparam int COUNT_W   = 6;

  localparam logic [7:0]  FUNC_READ_INPUT  = 8'h04;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [5:0]  COUNT_RESET      = 6'd1;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd150;

  // Input item kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Result item kinds.
  localparam logic [1:0] OUT_TX     = 2'd0;
  localparam logic [1:0] OUT_REG    = 2'd1;
  localparam logic [1:0] OUT_STATUS = 2'd2;

  // Poll status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_TIMEOUT = 2'd1;
  localparam logic [1:0] STAT_CRC     = 2'd2;
  localparam logic [1:0] STAT_HEADER  = 2'd3;

  // Register indexes, selected by paddr[2].
  localparam logic REG_IDX_COUNT   = 1'b0;
  localparam logic REG_IDX_TIMEOUT = 1'b1;

  // CRC-16/Modbus over one byte, reflected polynomial.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/modbus_rtu_input_register_poller_top.sv
// Modbus RTU master for function 04 (read input registers), single poll at a time.
// Depends on mbpoll_pkg for codes and the CRC byte update.
//
//   Channel  Signals                                   Direction  Transfer when
//   input    in_valid, in_stall, kind, slave_address,  in         in_valid && !in_stall
//            rx_byte
//   output   out_valid, out_stall, out_kind, tx_byte,  out        out_valid && !out_stall
//            reg_index, reg_value, poll_status, last
//   config   psel, penable, pwrite, paddr, pwdata,     in/out     psel && penable && pwrite
//            prdata, pready
//
// A received byte or a tick is taken while the block is idle. A start poll emits eight request
// bytes, one per cycle while the output is free. A good reply emits each register through
// a read of the register buffer memory and then an output load, then the status.
// Reset is synchronous; the register buffer has no clearing pass and needs none.
// The input is stalled whenever the block is busy emitting; the output register lets
// the block take the next item while the last result still waits.
module modbus_rtu_input_register_poller_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          kind,
  input  logic [7:0]          slave_address,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic [7:0]          tx_byte,
  output logic [4:0]          reg_index,
  output logic signed [15:0]  reg_value,
  output logic [1:0]          poll_status,
  output logic                last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TX,
    S_RD,
    S_REG,
    S_STAT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [5:0]  register_count;
  logic [15:0] response_timeout;

  // Poll state.
  logic        waiting;
  logic [7:0]  polled_slave;
  logic [5:0]  poll_count;
  logic [6:0]  bytes_rcvd;
  logic [15:0] rx_crc;
  logic [15:0] ticks;
  logic [7:0]  hdr [0:2];
  logic [7:0]  high_latch;
  logic [2:0]  tx_cnt;
  logic [15:0] tx_crc;
  logic [mbpoll_pkg::REG_IDX_W-1:0] rd_idx;
  logic [1:0]  stat_code;

  // Register buffer memory.
  logic [15:0] reg_mem [0:mbpoll_pkg::MAX_REGS-1];
  logic [15:0] rd_data;
  logic        mem_we;
  logic [mbpoll_pkg::REG_IDX_W-1:0] mem_waddr;

  logic        in_fire;
  logic        out_free;
  logic        out_load;
  logic        cfg_wr;
  logic [5:0]  count_clamped;
  logic [6:0]  frame_len;
  logic [6:0]  data_end;
  logic [6:0]  data_off;
  logic [6:0]  bytes_next;
  logic [15:0] rx_crc_next;
  logic [15:0] ticks_next;
  logic        hdr_bad;
  logic [7:0]  tx_sel;
  logic        rd_last;

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && ((state == S_TX) || (state == S_REG) || (state == S_STAT));
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      mbpoll_pkg::REG_IDX_COUNT:   prdata = {26'd0, register_count};
      mbpoll_pkg::REG_IDX_TIMEOUT: prdata = {16'd0, response_timeout};
      default:                     prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (register_count == 6'd0) begin
      count_clamped = 6'd1;
    end else if (register_count > 6'(mbpoll_pkg::MAX_REGS)) begin
      count_clamped = 6'(mbpoll_pkg::MAX_REGS);
    end else begin
      count_clamped = register_count;
    end
  end

  always_comb begin
    frame_len   = 7'd5 + {poll_count, 1'b0};
    data_end    = 7'd3 + {poll_count, 1'b0};
    data_off    = bytes_rcvd - 7'd3;
    bytes_next  = bytes_rcvd + 7'd1;
    rx_crc_next = mbpoll_pkg::crc_feed(rx_crc, rx_byte);
    ticks_next  = (ticks == 16'hFFFF) ? ticks : ticks + 16'd1;
    hdr_bad     = (hdr[0] != polled_slave) || (hdr[1] != mbpoll_pkg::FUNC_READ_INPUT) ||
                  (hdr[2] != {1'b0, poll_count, 1'b0});
    mem_we      = in_fire && (kind == mbpoll_pkg::KIND_BYTE) && waiting &&
                  (bytes_rcvd >= 7'd3) && (bytes_rcvd < data_end) && data_off[0];
    mem_waddr   = data_off[mbpoll_pkg::REG_IDX_W:1];
    rd_last     = ({1'b0, rd_idx} + 6'd1) == poll_count;
  end

  always_comb begin
    case (tx_cnt)
      3'd0:    tx_sel = polled_slave;
      3'd1:    tx_sel = mbpoll_pkg::FUNC_READ_INPUT;
      3'd5:    tx_sel = {2'b00, poll_count};
      3'd6:    tx_sel = tx_crc[7:0];
      3'd7:    tx_sel = tx_crc[15:8];
      default: tx_sel = 8'h00;
    endcase
  end

  // A register is written at least two bytes (the CRC) before the frame ends, so the read
  // that follows the final byte never meets a pending write to the same entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      reg_mem[mem_waddr] <= {high_latch, rx_byte};
    end
    rd_data <= reg_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      register_count   <= mbpoll_pkg::COUNT_RESET;
      response_timeout <= mbpoll_pkg::TIMEOUT_RESET;
      waiting          <= 1'b0;
      polled_slave     <= 8'd0;
      poll_count       <= 6'd1;
      bytes_rcvd       <= 7'd0;
      rx_crc           <= mbpoll_pkg::CRC_INIT;
      ticks            <= 16'd0;
      tx_cnt           <= 3'd0;
      tx_crc           <= mbpoll_pkg::CRC_INIT;
      rd_idx           <= '0;
      stat_code        <= mbpoll_pkg::STAT_OK;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      if (cfg_wr) begin
        case (paddr[2])
          mbpoll_pkg::REG_IDX_COUNT:   register_count   <= pwdata[5:0];
          mbpoll_pkg::REG_IDX_TIMEOUT: response_timeout <= pwdata[15:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (kind)
              mbpoll_pkg::KIND_START: begin
                waiting      <= 1'b1;
                polled_slave <= slave_address;
                poll_count   <= count_clamped;
                bytes_rcvd   <= 7'd0;
                rx_crc       <= mbpoll_pkg::CRC_INIT;
                ticks        <= 16'd0;
                tx_cnt       <= 3'd0;
                tx_crc       <= mbpoll_pkg::CRC_INIT;
                state        <= S_TX;
              end
              mbpoll_pkg::KIND_BYTE: begin
                if (waiting) begin
                  rx_crc     <= rx_crc_next;
                  bytes_rcvd <= bytes_next;
                  if (bytes_rcvd < 7'd3) begin
                    hdr[bytes_rcvd[1:0]] <= rx_byte;
                  end else if (bytes_rcvd < data_end && !data_off[0]) begin
                    high_latch <= rx_byte;
                  end
                  if (bytes_next == frame_len) begin
                    waiting <= 1'b0;
                    rd_idx  <= '0;
                    if (rx_crc_next != 16'd0) begin
                      stat_code <= mbpoll_pkg::STAT_CRC;
                      state     <= S_STAT;
                    end else if (hdr_bad) begin
                      stat_code <= mbpoll_pkg::STAT_HEADER;
                      state     <= S_STAT;
                    end else begin
                      stat_code <= mbpoll_pkg::STAT_OK;
                      state     <= S_RD;
                    end
                  end
                end
              end
              mbpoll_pkg::KIND_TICK: begin
                if (waiting) begin
                  ticks <= ticks_next;
                  if (ticks_next >= response_timeout) begin
                    waiting   <= 1'b0;
                    stat_code <= mbpoll_pkg::STAT_TIMEOUT;
                    state     <= S_STAT;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_TX: begin
          if (out_free) begin
            out_kind    <= mbpoll_pkg::OUT_TX;
            tx_byte     <= tx_sel;
            reg_index   <= 5'd0;
            reg_value   <= 16'sd0;
            poll_status <= 2'd0;
            last        <= (tx_cnt == 3'd7);
            if (tx_cnt < 3'd6) begin
              tx_crc <= mbpoll_pkg::crc_feed(tx_crc, tx_sel);
            end
            tx_cnt <= tx_cnt + 3'd1;
            if (tx_cnt == 3'd7) begin
              state <= S_IDLE;
            end
          end
        end
        S_RD: begin
          state <= S_REG;
        end
        S_REG: begin
          if (out_free) begin
            out_kind    <= mbpoll_pkg::OUT_REG;
            tx_byte     <= 8'd0;
            reg_index   <= 5'(rd_idx);
            reg_value   <= $signed(rd_data);
            poll_status <= 2'd0;
            last        <= 1'b0;
            if (rd_last) begin
              state <= S_STAT;
            end else begin
              rd_idx <= rd_idx + 1'b1;
              state  <= S_RD;
            end
          end
        end
        S_STAT: begin
          if (out_free) begin
            out_kind    <= mbpoll_pkg::OUT_STATUS;
            tx_byte     <= 8'd0;
            reg_index   <= 5'd0;
            reg_value   <= 16'sd0;
            poll_status <= stat_code;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Register values are only sent once the reply has closed the poll.
  a_reg_after_close: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == mbpoll_pkg::OUT_REG) |-> !waiting)
    else $error("register value sent while a reply is still expected");

  // An open poll never holds a complete frame.
  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    waiting |-> (bytes_rcvd < frame_len))
    else $error("byte count reached the frame length with the poll still open");

  // The read index stays inside the polled count while registers are sent.
  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_REG) |-> ({1'b0, rd_idx} < poll_count))
    else $error("register read index beyond the polled count");

  // A start transfer always leads into the request transmission.
  a_start_tx: assert property (@(posedge clk) disable iff (rst)
    (in_fire && kind == mbpoll_pkg::KIND_START) |=> (state == S_TX && waiting))
    else $error("start poll did not begin the request");

endmodule

### bench/poll_checker.sv
`timescale 1ns / 1ps
// Result checker for modbus_rtu_input_register_poller_top. It follows the item, result
// and register ports, works out each poll's results and compares them field by field.
// Depends on mbpoll_pkg for item kinds, result kinds, status codes and register indexes.
module poll_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [7:0]         slave_address,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_kind,
  input  logic [7:0]         tx_byte,
  input  logic [4:0]         reg_index,
  input  logic signed [15:0] reg_value,
  input  logic [1:0]         poll_status,
  input  logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 outstanding,
  output int                 results_seen
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [4:0]  idx;
    logic [15:0] value;
    logic [1:0]  status;
    logic        last;
  } poll_result_t;

  poll_result_t expected_q[$];

  // Configuration as last written, and the state of the poll in progress.
  logic [5:0]  count_reg;
  logic [15:0] timeout_reg;
  logic        awaiting;
  logic [7:0]  target_slave;
  int          latched_regs;
  int          frame_pos;
  logic [15:0] frame_crc;
  logic [15:0] tick_count;
  logic [7:0]  header [3];
  logic [7:0]  hi_byte;
  logic [15:0] reg_store [mbpoll_pkg::MAX_REGS];

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] c;
    c = acc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void push_result(input logic [1:0] k, input logic [7:0] tx,
                                      input logic [4:0] idx, input logic [15:0] value,
                                      input logic [1:0] status, input logic fin);
    poll_result_t r;
    r.kind   = k;
    r.tx     = tx;
    r.idx    = idx;
    r.value  = value;
    r.status = status;
    r.last   = fin;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_start(input logic [7:0] slave);
    logic [7:0]  req [8];
    logic [15:0] crc;
    int          n;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > mbpoll_pkg::MAX_REGS) n = mbpoll_pkg::MAX_REGS;
    req[0] = slave;
    req[1] = mbpoll_pkg::FUNC_READ_INPUT;
    req[2] = 8'h00;
    req[3] = 8'h00;
    req[4] = 8'h00;
    req[5] = 8'(n);
    crc = mbpoll_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc16_step(crc, req[i]);
    end
    req[6] = crc[7:0];
    req[7] = crc[15:8];
    for (int i = 0; i < 8; i++) begin
      push_result(mbpoll_pkg::OUT_TX, req[i], 5'd0, 16'd0, mbpoll_pkg::STAT_OK, i == 7);
    end
    awaiting     = 1'b1;
    target_slave = slave;
    latched_regs = n;
    frame_pos    = 0;
    frame_crc    = mbpoll_pkg::CRC_INIT;
    tick_count   = 16'd0;
  endfunction

  function automatic void predict_reply_byte(input logic [7:0] data);
    int pos;
    int off;
    if (!awaiting) return;
    pos = frame_pos;
    frame_crc = crc16_step(frame_crc, data);
    if (pos < 3) begin
      header[pos] = data;
    end else if (pos < 3 + 2 * latched_regs) begin
      off = pos - 3;
      if (off % 2 == 0) begin
        hi_byte = data;
      end else begin
        reg_store[off / 2] = {hi_byte, data};
      end
    end
    frame_pos = pos + 1;
    if (frame_pos < 5 + 2 * latched_regs) return;
    awaiting = 1'b0;
    // The CRC is judged before anything in the header.
    if (frame_crc != 16'd0) begin
      push_result(mbpoll_pkg::OUT_STATUS, 8'h00, 5'd0, 16'd0, mbpoll_pkg::STAT_CRC, 1'b1);
    end else if (header[0] != target_slave || header[1] != mbpoll_pkg::FUNC_READ_INPUT ||
                 header[2] != 8'(2 * latched_regs)) begin
      push_result(mbpoll_pkg::OUT_STATUS, 8'h00, 5'd0, 16'd0, mbpoll_pkg::STAT_HEADER,
                  1'b1);
    end else begin
      for (int i = 0; i < latched_regs; i++) begin
        push_result(mbpoll_pkg::OUT_REG, 8'h00, 5'(i), reg_store[i], mbpoll_pkg::STAT_OK,
                    1'b0);
      end
      push_result(mbpoll_pkg::OUT_STATUS, 8'h00, 5'd0, 16'd0, mbpoll_pkg::STAT_OK, 1'b1);
    end
  endfunction

  function automatic void predict_tick();
    if (!awaiting) return;
    if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
    if (tick_count >= timeout_reg) begin
      awaiting = 1'b0;
      push_result(mbpoll_pkg::OUT_STATUS, 8'h00, 5'd0, 16'd0, mbpoll_pkg::STAT_TIMEOUT,
                  1'b1);
    end
  endfunction

  function automatic void check_result();
    poll_result_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: out_kind %0d tx_byte %0h reg_index %0d",
             out_kind, tx_byte, reg_index);
      fail_count++;
      return;
    end
    e = expected_q.pop_front();
    if (out_kind !== e.kind) begin
      $error("out_kind: expected %0d, got %0d", e.kind, out_kind);
      fail_count++;
    end
    if (tx_byte !== e.tx) begin
      $error("tx_byte: expected %02h, got %02h", e.tx, tx_byte);
      fail_count++;
    end
    if (reg_index !== e.idx) begin
      $error("reg_index: expected %0d, got %0d", e.idx, reg_index);
      fail_count++;
    end
    if (reg_value !== e.value) begin
      $error("reg_value: expected %0d, got %0d", $signed(e.value), reg_value);
      fail_count++;
    end
    if (poll_status !== e.status) begin
      $error("poll_status: expected %0d, got %0d", e.status, poll_status);
      fail_count++;
    end
    if (last !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, last);
      fail_count++;
    end
  endfunction

  // Results are taken first: a transfer on the input at the same edge cannot have
  // produced them. A register write at that edge only affects later items.
  always @(posedge clk) begin
    if (rst) begin
      expected_q.delete();
      count_reg    = mbpoll_pkg::COUNT_RESET;
      timeout_reg  = mbpoll_pkg::TIMEOUT_RESET;
      awaiting     = 1'b0;
      target_slave = 8'h00;
      latched_regs = 1;
      frame_pos    = 0;
      frame_crc    = mbpoll_pkg::CRC_INIT;
      tick_count   = 16'd0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        case (kind)
          mbpoll_pkg::KIND_START: predict_start(slave_address);
          mbpoll_pkg::KIND_BYTE:  predict_reply_byte(rx_byte);
          mbpoll_pkg::KIND_TICK:  predict_tick();
          default: ;
        endcase
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == mbpoll_pkg::REG_IDX_TIMEOUT) begin
          timeout_reg = pwdata[15:0];
        end else begin
          count_reg = pwdata[5:0];
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for modbus_rtu_input_register_poller_top: clock, reset, register
// set-up, poll and reply stimulus, receiver stalls and the verdict.
// Depends on mbpoll_pkg and on poll_checker, which does all prediction and comparison.
module tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int NUM_PHASES  = 4;

  // Ways of spoiling a reply frame.
  localparam int FLAW_NONE  = 0;
  localparam int FLAW_CRC   = 1;
  localparam int FLAW_SLAVE = 2;
  localparam int FLAW_FUNC  = 3;
  localparam int FLAW_COUNT = 4;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         kind;
  logic [7:0]         slave_address;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_kind;
  logic [7:0]         tx_byte;
  logic [4:0]         reg_index;
  logic signed [15:0] reg_value;
  logic [1:0]         poll_status;
  logic               last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int outstanding;
  int results_seen;

  int   items_sent;
  int   polls;
  int   frames_good;
  int   frames_flawed;
  int   run_left;
  bit   hold_req;
  logic [5:0]  count_cfg;
  logic [15:0] timeout_cfg;

  modbus_rtu_input_register_poller_top u_dut (.*);
  poll_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] frame_crc_next(input logic [15:0] acc,
                                                 input logic [7:0] data);
    logic [15:0] c;
    c = acc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ mbpoll_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic int regs_per_poll();
    if (count_cfg == 6'd0) return 1;
    if (count_cfg > mbpoll_pkg::MAX_REGS) return mbpoll_pkg::MAX_REGS;
    return count_cfg;
  endfunction

  // One input transfer, after a random gap; valid stays high across back-to-back items.
  task automatic offer(input logic [1:0] k, input logic [7:0] slave, input logic [7:0] data);
    int gap;
    int r;
    gap = 0;
    if (run_left > 0) begin
      run_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) run_left = $urandom_range(15, 40);
      else if (r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 40);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    slave_address <= slave;
    rx_byte       <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Sends a reply of 5 + 2n bytes, with ticks mixed in but never enough to time out.
  task automatic send_reply(input logic [7:0] slave, input int n, input logic [15:0] first_val,
                            input int flaw, input int tick_room);
    logic [7:0]  frame [5 + 2 * mbpoll_pkg::MAX_REGS];
    logic [15:0] v;
    logic [15:0] crc;
    int          len;
    int          pos;
    int          room;
    len  = 5 + 2 * n;
    room = tick_room;
    frame[0] = slave;
    frame[1] = mbpoll_pkg::FUNC_READ_INPUT;
    frame[2] = 8'(2 * n);
    for (int i = 0; i < n; i++) begin
      v = (i == 0) ? first_val : 16'($urandom);
      frame[3 + 2 * i] = v[15:8];
      frame[4 + 2 * i] = v[7:0];
    end
    if (flaw == FLAW_SLAVE) frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_FUNC) frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_COUNT) frame[2] = frame[2] ^ 8'($urandom_range(1, 255));
    crc = mbpoll_pkg::CRC_INIT;
    for (int i = 0; i < len - 2; i++) begin
      crc = frame_crc_next(crc, frame[i]);
    end
    frame[len - 2] = crc[7:0];
    frame[len - 1] = crc[15:8];
    // A single flipped bit always spoils a CRC-16.
    if (flaw == FLAW_CRC) begin
      pos = $urandom_range(0, len - 1);
      frame[pos] = frame[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    if (flaw == FLAW_NONE) frames_good++;
    else frames_flawed++;
    for (int i = 0; i < len; i++) begin
      if (room > 0 && $urandom_range(0, 99) < 12) begin
        offer(mbpoll_pkg::KIND_TICK, 8'($urandom), 8'($urandom));
        room--;
      end
      offer(mbpoll_pkg::KIND_BYTE, 8'($urandom), frame[i]);
    end
  endtask

  task automatic random_poll();
    logic [7:0] slave;
    int         n;
    int         r;
    int         room;
    n     = regs_per_poll();
    r     = $urandom_range(0, 99);
    slave = 8'($urandom);
    room  = (timeout_cfg >= 2) ? ((timeout_cfg > 5) ? 4 : timeout_cfg - 1) : 0;
    offer(mbpoll_pkg::KIND_START, slave, 8'($urandom));
    polls++;
    if (r < 55) begin
      send_reply(slave, n, 16'($urandom), FLAW_NONE, room);
    end else if (r < 75) begin
      send_reply(slave, n, 16'($urandom), $urandom_range(FLAW_CRC, FLAW_COUNT), room);
    end else if (r < 90) begin
      // Short reply; where the timeout is short, tick until it runs out, otherwise the
      // next start poll abandons it.
      repeat ($urandom_range(0, 4 + 2 * n))
        offer(mbpoll_pkg::KIND_BYTE, 8'($urandom), 8'($urandom));
      if (timeout_cfg <= 8) begin
        repeat ((timeout_cfg == 0) ? 1 : timeout_cfg)
          offer(mbpoll_pkg::KIND_TICK, 8'($urandom), 8'($urandom));
      end
    end else begin
      repeat ($urandom_range(1, 4)) offer(2'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off when asked for.
  initial begin
    int stall_left;
    int calm_left;
    int r;
    stall_left = 0;
    calm_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (calm_left > 0) begin
        out_stall <= 1'b0;
        calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        out_stall <= (r >= 55);
        if (r < 10) calm_left = $urandom_range(10, 60);
        else if (r >= 96) stall_left = $urandom_range(10, 30);
        else if (r >= 55) stall_left = $urandom_range(0, 2);
      end
    end
  end

  // Ends the run when no transfer of any kind has happened for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pwrite))
        quiet = 0;
      else
        quiet++;
    end
    $error("no transfer for %0d cycles, %0d results still expected", QUIET_LIMIT, outstanding);
    $display("FAIL modbus_rtu_input_register_poller_top");
    $finish;
  end

  initial begin
    logic [31:0] cnt_word;
    logic [31:0] tmo_word;
    logic [7:0]  slave_pick;
    int          first;
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = mbpoll_pkg::KIND_START;
    slave_address = 8'h00;
    rx_byte       = 8'h00;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    hold_req      = 1'b0;
    run_left      = 0;
    count_cfg     = mbpoll_pkg::COUNT_RESET;
    timeout_cfg   = mbpoll_pkg::TIMEOUT_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, on the reset settings of one register and a timeout of 150.
    offer(mbpoll_pkg::KIND_BYTE, 8'h00, 8'hFF);
    offer(mbpoll_pkg::KIND_TICK, 8'hFF, 8'h00);
    offer(KIND_UNUSED, 8'hFF, 8'hFF);
    offer(mbpoll_pkg::KIND_START, 8'h00, 8'h00);
    polls++;
    send_reply(8'h00, 1, 16'h8000, FLAW_NONE, 2);
    offer(mbpoll_pkg::KIND_BYTE, 8'h00, 8'h55);
    // A second start abandons the first poll without a status.
    offer(mbpoll_pkg::KIND_START, 8'hFF, 8'hFF);
    offer(mbpoll_pkg::KIND_START, 8'hA5, 8'h5A);
    polls += 2;
    send_reply(8'hA5, 1, 16'h7FFF, FLAW_NONE, 0);
    settle();
    cfg_write(mbpoll_pkg::REG_IDX_TIMEOUT, 32'd2);
    timeout_cfg = 16'd2;
    offer(mbpoll_pkg::KIND_START, 8'h81, 8'h00);
    polls++;
    offer(mbpoll_pkg::KIND_TICK, 8'h00, 8'h00);
    offer(mbpoll_pkg::KIND_TICK, 8'h00, 8'h00);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          cnt_word = 32'hFFFF_FFC0;
          tmo_word = 32'h0000_0000;
        end
        1: begin
          cnt_word = 32'd2;
          tmo_word = 32'hFFFF_FFFF;
        end
        2: begin
          cnt_word = 32'd63;
          tmo_word = 32'd1;
        end
        default: begin
          cnt_word = 32'd3;
          tmo_word = 32'd5;
        end
      endcase
      settle();
      cfg_write(mbpoll_pkg::REG_IDX_COUNT, cnt_word);
      cfg_write(mbpoll_pkg::REG_IDX_TIMEOUT, tmo_word);
      count_cfg   = cnt_word[5:0];
      timeout_cfg = tmo_word[15:0];
      // The receiver holds off while the next request goes out, so the block backs up.
      if (p == 1) hold_req = 1'b1;
      first = items_sent;
      if (regs_per_poll() == mbpoll_pkg::MAX_REGS) begin
        slave_pick = 8'($urandom);
        offer(mbpoll_pkg::KIND_START, slave_pick, 8'($urandom));
        polls++;
        send_reply(slave_pick, mbpoll_pkg::MAX_REGS, 16'($urandom), FLAW_NONE, 0);
      end else begin
        while (items_sent - first < 4) random_poll();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    $display("Run covered %0d input items over %0d polls: %0d clean replies, %0d damaged.",
             items_sent, polls, frames_good, frames_flawed);
    $display("%0d results compared; register counts 0 to 63, timeouts 0 to 65535.",
             results_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS modbus_rtu_input_register_poller_top");
    end else begin
      $display("FAIL modbus_rtu_input_register_poller_top");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/mbpoll_pkg.sv
rtl/core/modbus_rtu_input_register_poller_top.sv
bench/poll_checker.sv
bench/tb.sv
